/* src/aar_pkg.sv */
// Shared types and constants for the axis-angle rotation matrix core.
// CORDIC arctangent table, internal widths and the inter-module structs.
// No dependencies.
package aar_pkg;

  // latency of the axis normalisation pipeline, in register stages
  localparam int AX_LAT       = 66;
  localparam int CORDIC_STEPS = 28;
  localparam int ANG_W        = 24;
  localparam int XY_W         = 35;
  localparam int Z_W          = 33;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 35'sd2608131496;
  localparam logic signed [32:0]     ONE_Q30     = 33'sd1073741824;

  // arctan(2^-i) in degrees, 24 fractional bits
  localparam logic signed [Z_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
    33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
    33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
    33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
    33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
    33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
    33'sd917,       33'sd458,       33'sd229,       33'sd115,
    33'sd57,        33'sd29,        33'sd14,        33'sd7
  };

  typedef enum logic [1:0] {
    QUAD0 = 2'd0,
    QUAD1 = 2'd1,
    QUAD2 = 2'd2,
    QUAD3 = 2'd3
  } quad_t;

  // sine, cosine and one minus cosine, 30 fractional bits
  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
    logic signed [32:0] omc;
  } trig_t;

  // unit axis, 30 fractional bits, and the zero-axis flag
  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic               zero;
  } axis_t;

endpackage

/* src/aar_axis_norm.sv */
// Axis normalisation: sum of squares, bit-per-stage square root and
// bit-per-stage division of each component by the root. Uses aar_pkg.
module aar_axis_norm
  import aar_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] vx,
  input  logic signed [15:0] vy,
  input  logic signed [15:0] vz,
  output axis_t              axis
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;

  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        n2;

  logic [63:0]        sq_bits [SQ_STEPS+1];
  logic [34:0]        sq_rem  [SQ_STEPS+1];
  logic [31:0]        sq_root [SQ_STEPS+1];
  logic signed [15:0] sq_v    [SQ_STEPS+1][3];
  logic               sq_zero [SQ_STEPS+1];

  logic [31:0]        dv_s    [DIV_STEPS+1];
  logic [62:0]        dv_r    [DIV_STEPS+1][3];
  logic [30:0]        dv_q    [DIV_STEPS+1][3];
  logic               dv_neg  [DIV_STEPS+1][3];
  logic               dv_zero [DIV_STEPS+1];

  always_comb begin
    sqx = vx * vx;
    sqy = vy * vy;
    sqz = vz * vz;
    n2  = 32'(sqx) + 32'(sqy) + 32'(sqz);
  end

  always_ff @(posedge clk) begin
    logic [34:0] cur;
    logic [34:0] trial;
    logic [15:0] mag;
    logic [62:0] dsh;
    if (en) begin
      sq_bits[0] <= {n2, 32'd0};
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_v[0][0] <= vx;
      sq_v[0][1] <= vy;
      sq_v[0][2] <= vz;
      sq_zero[0] <= (vx == 16'sd0) && (vy == 16'sd0) && (vz == 16'sd0);

      // one root bit per stage
      for (int j = 0; j < SQ_STEPS; j++) begin
        cur   = {sq_rem[j][32:0], sq_bits[j][63:62]};
        trial = {1'b0, sq_root[j], 2'b01};
        sq_bits[j+1] <= {sq_bits[j][61:0], 2'b00};
        if (cur >= trial) begin
          sq_rem[j+1]  <= cur - trial;
          sq_root[j+1] <= {sq_root[j][30:0], 1'b1};
        end else begin
          sq_rem[j+1]  <= cur;
          sq_root[j+1] <= {sq_root[j][30:0], 1'b0};
        end
        for (int k = 0; k < 3; k++) sq_v[j+1][k] <= sq_v[j][k];
        sq_zero[j+1] <= sq_zero[j];
      end

      // dividend carries half the divisor for round half away from zero
      dv_s[0]    <= sq_root[SQ_STEPS];
      dv_zero[0] <= sq_zero[SQ_STEPS];
      for (int k = 0; k < 3; k++) begin
        mag = sq_v[SQ_STEPS][k][15] ? 16'(-sq_v[SQ_STEPS][k]) : 16'(sq_v[SQ_STEPS][k]);
        dv_r[0][k]   <= (63'(mag) << 46) + 63'(sq_root[SQ_STEPS] >> 1);
        dv_q[0][k]   <= '0;
        dv_neg[0][k] <= sq_v[SQ_STEPS][k][15];
      end

      // one quotient bit per stage, all three lanes side by side
      for (int s = 0; s < DIV_STEPS; s++) begin
        dv_s[s+1]    <= dv_s[s];
        dv_zero[s+1] <= dv_zero[s];
        for (int k = 0; k < 3; k++) begin
          dsh = 63'(dv_s[s]) << (DIV_STEPS - 1 - s);
          dv_neg[s+1][k] <= dv_neg[s][k];
          if (dv_r[s][k] >= dsh) begin
            dv_r[s+1][k] <= dv_r[s][k] - dsh;
            dv_q[s+1][k] <= {dv_q[s][k][29:0], 1'b1};
          end else begin
            dv_r[s+1][k] <= dv_r[s][k];
            dv_q[s+1][k] <= {dv_q[s][k][29:0], 1'b0};
          end
        end
      end

      axis.ux   <= dv_neg[DIV_STEPS][0] ? -$signed({1'b0, dv_q[DIV_STEPS][0]})
                                        :  $signed({1'b0, dv_q[DIV_STEPS][0]});
      axis.uy   <= dv_neg[DIV_STEPS][1] ? -$signed({1'b0, dv_q[DIV_STEPS][1]})
                                        :  $signed({1'b0, dv_q[DIV_STEPS][1]});
      axis.uz   <= dv_neg[DIV_STEPS][2] ? -$signed({1'b0, dv_q[DIV_STEPS][2]})
                                        :  $signed({1'b0, dv_q[DIV_STEPS][2]});
      axis.zero <= dv_zero[DIV_STEPS];
    end
  end

endmodule

/* src/aar_sincos.sv */
// Angle path: delay to match the axis path, reduction modulo 360 degrees
// with quadrant split, 28-stage CORDIC and quadrant fold. Uses aar_pkg.
module aar_sincos
  import aar_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7
)
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] angle_deg,
  output trig_t              trig
);

  localparam longint PER    = 64'sd360 <<< ANGLE_FRAC_BITS;
  localparam longint QUAD   = 64'sd90 <<< ANGLE_FRAC_BITS;
  localparam longint OFFPER = ((65536 + PER - 1) / PER) * PER;
  localparam longint AMAX   = 65535 + OFFPER;
  localparam int     AW     = $clog2(AMAX + 1);
  localparam int     QSTEPS = $clog2(AMAX / QUAD + 1);
  localparam int     DLY    = AX_LAT - QSTEPS - 31;
  localparam int     ZSH    = ANG_W - ANGLE_FRAC_BITS;

  logic signed [16:0]     adly [DLY];
  logic [AW-1:0]          rr   [QSTEPS+1];
  logic [1:0]             qq   [QSTEPS+1];
  logic signed [XY_W-1:0] cx   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz   [CORDIC_STEPS+1];
  logic [1:0]             cq   [CORDIC_STEPS+1];

  logic signed [31:0] c0, s0, sn, cs;

  always_comb begin
    c0 = 32'((cx[CORDIC_STEPS] + 35'sd2) >>> 2);
    s0 = 32'((cy[CORDIC_STEPS] + 35'sd2) >>> 2);
    case (quad_t'(cq[CORDIC_STEPS]))
      QUAD0:   begin sn = s0;  cs = c0;  end
      QUAD1:   begin sn = c0;  cs = -s0; end
      QUAD2:   begin sn = -s0; cs = -c0; end
      QUAD3:   begin sn = -c0; cs = s0;  end
      default: begin sn = s0;  cs = c0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adly[0] <= angle_deg;
      for (int i = 1; i < DLY; i++) adly[i] <= adly[i-1];

      // shift into the non-negative range, then divide by a quarter turn
      rr[0] <= AW'(64'(adly[DLY-1]) + OFFPER);
      qq[0] <= 2'd0;
      for (int s = 0; s < QSTEPS; s++) begin
        if (64'(rr[s]) >= 64'(QUAD << (QSTEPS - 1 - s))) begin
          rr[s+1] <= rr[s] - AW'(QUAD << (QSTEPS - 1 - s));
          qq[s+1] <= (QSTEPS - 1 - s < 2) ? (qq[s] | (2'd1 << (QSTEPS - 1 - s))) : qq[s];
        end else begin
          rr[s+1] <= rr[s];
          qq[s+1] <= qq[s];
        end
      end

      cx[0] <= CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= Z_W'(64'(rr[QSTEPS]) << ZSH);
      cq[0] <= qq[QSTEPS];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (!cz[i][Z_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_DEG[i];
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_DEG[i];
        end
        cq[i+1] <= cq[i];
      end

      trig.sn  <= sn;
      trig.cs  <= cs;
      trig.omc <= ONE_Q30 - 33'(cs);
    end
  end

endmodule

/* src/axis_angle_rotation_matrix_core.sv */
// Axis-angle to 3x3 rotation matrix, top level: handshake, valid pipeline
// and the product and sum stages. Uses aar_pkg, aar_axis_norm, aar_sincos.
//
//  channel | direction | tdata fields (lowest first)             | tuser
//  s_      | in        | angle_deg, axis_x, axis_y, axis_z        | -
//  m_      | out       | r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2 | zero_axis
//
// One transfer per cycle in and out while the output is not stalled. The
// axis path holds the 32-stage square root and 31-stage divider; three
// product and sum stages follow. The angle path is delayed to match it.
// The whole pipeline advances together; a stall at the output holds every
// stage. Reset clears the valid bits only.
module axis_angle_rotation_matrix_core
  import aar_pkg::*;
#(
  parameter int FRAC_BITS       = 14,
  parameter int ANGLE_FRAC_BITS = 7
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // angle_deg, axis_x, axis_y, axis_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2
  output logic [0:0]   m_tuser    // zero_axis
);

  localparam int     LAT = AX_LAT + 3;
  localparam int     SH  = 30 - FRAC_BITS;
  localparam longint RB  = (64'sd1 <<< SH) >>> 1;

  logic           en;
  logic [LAT-1:0] vld;

  axis_t axis;
  trig_t trig;

  logic signed [32:0] su_a [3];
  logic signed [32:0] pp_a [6];
  trig_t              trig_a;
  logic               zero_a;

  logic signed [32:0] su_b [3];
  logic signed [33:0] uu_b [6];
  logic signed [31:0] cs_b;
  logic               zero_b;

  logic signed [35:0] m [9];

  function automatic logic signed [32:0] rnd30(input logic signed [63:0] p);
    return 33'((p + 64'sd536870912) >>> 30);
  endfunction

  function automatic logic [15:0] finish(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + 36'(RB)) >>> SH;
    if (r > 36'sd32767) r = 36'sd32767;
    if (r < -36'sd32768) r = -36'sd32768;
    return 16'(r);
  endfunction

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  aar_axis_norm u_axis (
    .clk  (clk),
    .en   (en),
    .vx   (s_tdata[32:17]),
    .vy   (s_tdata[48:33]),
    .vz   (s_tdata[64:49]),
    .axis (axis)
  );

  aar_sincos #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_sincos (
    .clk       (clk),
    .en        (en),
    .angle_deg (s_tdata[16:0]),
    .trig      (trig)
  );

  always_comb begin
    // entry index is column * 3 + row
    m[0] = 36'(cs_b) + 36'(uu_b[0]);
    m[1] = 36'(uu_b[3]) + 36'(su_b[2]);
    m[2] = 36'(uu_b[4]) - 36'(su_b[1]);
    m[3] = 36'(uu_b[3]) - 36'(su_b[2]);
    m[4] = 36'(cs_b) + 36'(uu_b[1]);
    m[5] = 36'(uu_b[5]) + 36'(su_b[0]);
    m[6] = 36'(uu_b[4]) + 36'(su_b[1]);
    m[7] = 36'(uu_b[5]) - 36'(su_b[0]);
    m[8] = 36'(cs_b) + 36'(uu_b[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // sine times axis, and the six distinct axis outer products
      su_a[0] <= rnd30(64'(trig.sn) * 64'(axis.ux));
      su_a[1] <= rnd30(64'(trig.sn) * 64'(axis.uy));
      su_a[2] <= rnd30(64'(trig.sn) * 64'(axis.uz));
      pp_a[0] <= rnd30(64'(axis.ux) * 64'(axis.ux));
      pp_a[1] <= rnd30(64'(axis.uy) * 64'(axis.uy));
      pp_a[2] <= rnd30(64'(axis.uz) * 64'(axis.uz));
      pp_a[3] <= rnd30(64'(axis.ux) * 64'(axis.uy));
      pp_a[4] <= rnd30(64'(axis.ux) * 64'(axis.uz));
      pp_a[5] <= rnd30(64'(axis.uy) * 64'(axis.uz));
      trig_a  <= trig;
      zero_a  <= axis.zero;

      for (int i = 0; i < 6; i++) begin
        uu_b[i] <= 34'(rnd30(64'(trig_a.omc) * 64'(pp_a[i])));
      end
      for (int i = 0; i < 3; i++) su_b[i] <= su_a[i];
      cs_b   <= trig_a.cs;
      zero_b <= zero_a;

      for (int i = 0; i < 9; i++) begin
        m_tdata[16*i +: 16] <= zero_b ? 16'd0 : finish(m[i]);
      end
      m_tuser[0] <= zero_b;
    end
  end

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero axis result carries nonzero entries");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid pipeline moved during a stall");

  a_take_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted transfer missing from the first stage");

endmodule

/* bench/axis_angle_rotation_matrix_core_tb.sv */
// Testbench for axis_angle_rotation_matrix_core: random and directed angle/axis
// transfers, checked entry by entry against a fixed-point Rodrigues predictor.
// Depends on aar_pkg and the core RTL only.
module axis_angle_rotation_matrix_core_tb;
  import aar_pkg::*;

  localparam int FRAC     = 14;
  localparam int ANG_FRAC = 7;
  localparam int LAT      = 69;
  localparam int LIMIT    = 400000;

  typedef struct packed {
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    logic signed [16:0] ang;
  } rot_req_t;

  typedef struct {
    logic [143:0] ent;
    logic         zero;
  } rot_mat_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;
  logic [0:0]   m_tuser;

  rot_req_t pending_q[$];
  rot_mat_t matrix_q[$];
  int       errors;
  int       checked;
  int       cycles;
  int       zero_seen;
  int       send_gap;
  int       recv_gap;
  int       hold_off;
  bit       feed_done;
  bit       in_acc;

  axis_angle_rotation_matrix_core #(.FRAC_BITS(FRAC), .ANGLE_FRAC_BITS(ANG_FRAC)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    if (s <= 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint div_away(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic [15:0] to_entry(longint q30);
    longint v;
    v = round_shr(q30, 30 - FRAC);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic rot_mat_t predict_matrix(rot_req_t r);
    rot_mat_t res;
    longint   v[3];
    longint   u[3];
    longint   m[9];
    longint   su[3];
    longint   uu[3][3];
    longint   n2, sq, per, rem, quad, t, x, y, xs, ys, c0, s0, sn, cs, omc;
    quad_t    qd;
    v[0] = r.ax;
    v[1] = r.ay;
    v[2] = r.az;
    n2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    res.ent = '0;
    res.zero = 1'b0;
    if (n2 == 0) begin
      res.zero = 1'b1;
      return res;
    end
    sq = int_sqrt(longint'(n2) << 32);
    for (int i = 0; i < 3; i++) u[i] = div_away(v[i] * (longint'(1) << 46), sq);
    per = longint'(360) << ANG_W;
    quad = longint'(90) << ANG_W;
    rem = (longint'(r.ang) * (longint'(1) << (ANG_W - ANG_FRAC))) % per;
    if (rem < 0) rem += per;
    qd = quad_t'(rem / quad);
    t = rem - (rem / quad) * quad;
    x = 64'sd2608131496;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (t >= 0) begin
        x -= ys; y += xs; t -= longint'(ATAN_DEG[i]);
      end else begin
        x += ys; y -= xs; t += longint'(ATAN_DEG[i]);
      end
    end
    c0 = round_shr(x, 2);
    s0 = round_shr(y, 2);
    case (qd)
      QUAD0: begin sn = s0; cs = c0; end
      QUAD1: begin sn = c0; cs = -s0; end
      QUAD2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
    omc = (longint'(1) << 30) - cs;
    for (int i = 0; i < 3; i++) begin
      su[i] = round_shr(sn * u[i], 30);
      for (int j = 0; j < 3; j++) uu[i][j] = round_shr(omc * round_shr(u[i] * u[j], 30), 30);
    end
    m[0] = cs + uu[0][0];
    m[1] = uu[1][0] + su[2];
    m[2] = uu[2][0] - su[1];
    m[3] = uu[0][1] - su[2];
    m[4] = cs + uu[1][1];
    m[5] = uu[2][1] + su[0];
    m[6] = uu[0][2] + su[1];
    m[7] = uu[1][2] - su[0];
    m[8] = cs + uu[2][2];
    for (int k = 0; k < 9; k++) res.ent[16*k +: 16] = to_entry(m[k]);
    return res;
  endfunction

  function automatic rot_req_t make_req(int ang, int ax, int ay, int az);
    rot_req_t r;
    r.ang = 17'(ang);
    r.ax = 16'(ax);
    r.ay = 16'(ay);
    r.az = 16'(az);
    return r;
  endfunction

  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return 0;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int ang;
    pending_q.push_back(make_req(0, 16384, 0, 0));
    pending_q.push_back(make_req(46080, 0, 16384, 0));
    pending_q.push_back(make_req(-46080, 0, 0, 16384));
    pending_q.push_back(make_req(11520, 0, 0, 16384));
    pending_q.push_back(make_req(23040, 0, 0, -16384));
    pending_q.push_back(make_req(34560, 16384, 16384, 16384));
    pending_q.push_back(make_req(-11520, 1, 0, 0));
    pending_q.push_back(make_req(1000, 0, 0, 0));
    pending_q.push_back(make_req(-65536, 0, 0, 0));
    pending_q.push_back(make_req(65535, 32767, 32767, 32767));
    pending_q.push_back(make_req(-65536, -32768, -32768, -32768));
    pending_q.push_back(make_req(46079, -32768, 32767, 1));
    pending_q.push_back(make_req(-1, -1, -1, -1));
    pending_q.push_back(make_req(5760, 12345, -23456, 3210));
    pending_q.push_back(make_req(-40000, 1, 1, 0));
    pending_q.push_back(make_req(11519, 0, -1, 0));
    pending_q.push_back(make_req(17280, 300, 400, 0));
    pending_q.push_back(make_req(-17280, -21000, 5, 9999));
    for (int n = 0; n < 400; n++) begin
      case ($urandom_range(0, 4))
        0: ang = int'($urandom_range(0, 131071)) - 65536;
        1: ang = int'($urandom_range(0, 8)) * 5760 + int'($urandom_range(0, 2)) - 1 - 23040;
        default: ang = int'($urandom_range(0, 92160)) - 46080;
      endcase
      pending_q.push_back(make_req(ang, rand_comp(), rand_comp(), rand_comp()));
    end
    feed_done = 1'b1;
  end

  // driver: present a transfer, then wait a random gap; pause once mid-run
  // until the pipeline has drained
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap <= 0;
    end else if (s_tvalid && !in_acc) begin
    end else if (send_gap > 0) begin
      s_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_q.size() == 218 && matrix_q.size() != 0) begin
      s_tvalid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      rot_req_t r;
      r = pending_q.pop_front();
      s_tdata  <= 72'(r);
      s_tvalid <= 1'b1;
      send_gap <= $urandom_range(0, 7) < 3 ? 0 : $urandom_range(0, 3);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver readiness: random gaps, one long hold-off to back the pipe up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
      hold_off <= 0;
    end else if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (checked == 60 && m_tready) begin
      m_tready <= 1'b0;
      hold_off <= 250;
    end else if (recv_gap > 0) begin
      m_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_tready <= 1'b1;
      recv_gap <= $urandom_range(0, 7) < 3 ? 0 : $urandom_range(0, 3);
    end
  end

  // record expectations on input transfers
  always @(posedge clk) begin
    in_acc <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) matrix_q.push_back(predict_matrix(s_tdata[64:0]));
  end

  // monitor: compare every output transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (matrix_q.size() == 0) begin
        $error("unexpected output transfer");
        errors++;
      end else begin
        rot_mat_t e;
        e = matrix_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (m_tdata[16*k +: 16] !== e.ent[16*k +: 16]) begin
            $error("r%0dc%0d: expected %0d, got %0d", k % 3, k / 3,
                   $signed(e.ent[16*k +: 16]), $signed(m_tdata[16*k +: 16]));
            errors++;
          end
        end
        if (m_tuser[0] !== e.zero) begin
          $error("zero_axis: expected %0b, got %0b", e.zero, m_tuser[0]);
          errors++;
        end
        if (e.zero) zero_seen++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("axis_angle_rotation_matrix_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (feed_done && pending_q.size() == 0 && !s_tvalid);
    wait (matrix_q.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    $display("checked %0d rotation matrices (%0d with a zero axis), angles across",
             checked, zero_seen);
    $display("all quadrants and beyond one turn, with input and output stalls");
    if (errors == 0) begin
      $display("axis_angle_rotation_matrix_core_tb: done, clean");
    end else begin
      $display("axis_angle_rotation_matrix_core_tb: done, errors");
    end
    $finish;
  end
endmodule

/* sim.f */
src/aar_pkg.sv
src/aar_axis_norm.sv
src/aar_sincos.sv
src/axis_angle_rotation_matrix_core.sv
bench/axis_angle_rotation_matrix_core_tb.sv
